@@ rtl/bpr_pkg.sv @@
// shared types, constants and microcode for the bus presence roster
package bpr_pkg;

  localparam int TBL_ENTRIES = 32;
  localparam int SLOT_W      = (TBL_ENTRIES > 1) ? $clog2(TBL_ENTRIES) : 1;
  localparam int CTR_W       = $clog2(TBL_ENTRIES + 1);

  localparam int ADDR_W      = 7;
  localparam int MISS_W      = 8;
  localparam int QS_W        = 5;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int OUT_CNT_W   = 6;
  localparam int OUT_CNT_MAX = (2 ** OUT_CNT_W) - 1;
  localparam int ENTRY_W     = MISS_W + ADDR_W;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [MISS_W-1:0] MISS_MAX   = '1;
  localparam logic [MISS_W-1:0] RST_STALE  = 8'd3;
  localparam logic [MISS_W-1:0] RST_FORGET = 8'd6;
  localparam logic [ADDR_W-1:0] RST_WIN_LO = 7'd8;
  localparam logic [ADDR_W-1:0] RST_WIN_HI = 7'd39;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROBE  = 3'd0,
    KIND_EOS    = 3'd1,
    KIND_FORGET = 3'd2,
    KIND_BUMP   = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STALE  = 2'd0,
    CFG_FORGET = 2'd1,
    CFG_WIN_LO = 2'd2,
    CFG_WIN_HI = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [MISS_W-1:0] misses;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // datapath action of one microcode step
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_FIND,
    ACT_AGE,
    ACT_QREAD,
    ACT_APPLY
  } act_t;

  // condition that moves the step counter to the target
  typedef enum logic [1:0] {
    COND_DISPATCH,
    COND_CTR_END,
    COND_ALWAYS,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [2:0] {
    UPC_IDLE,
    UPC_FIND,
    UPC_AGE,
    UPC_QREAD,
    UPC_APPLY
  } upc_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic ctr_end;
    logic out_free;
  } useq_flags_t;

  // control store: a step holds until its condition is met
  function automatic ctl_t useq_rom(input upc_t pc);
    unique case (pc)
      UPC_IDLE:  return '{act: ACT_LOAD,  cond: COND_DISPATCH, target: UPC_IDLE};
      UPC_FIND:  return '{act: ACT_FIND,  cond: COND_CTR_END,  target: UPC_APPLY};
      UPC_AGE:   return '{act: ACT_AGE,   cond: COND_CTR_END,  target: UPC_APPLY};
      UPC_QREAD: return '{act: ACT_QREAD, cond: COND_ALWAYS,   target: UPC_APPLY};
      UPC_APPLY: return '{act: ACT_APPLY, cond: COND_OUT_FREE, target: UPC_IDLE};
      default:   return '{act: ACT_NONE,  cond: COND_ALWAYS,   target: UPC_IDLE};
    endcase
  endfunction

  function automatic upc_t useq_dispatch(input kind_t kind);
    unique case (kind) inside
      KIND_PROBE, KIND_FORGET, KIND_BUMP: return UPC_FIND;
      KIND_EOS:                           return UPC_AGE;
      KIND_QUERY:                         return UPC_QREAD;
      default:                            return UPC_APPLY;
    endcase
  endfunction

  function automatic logic [MISS_W-1:0] sat_inc(input logic [MISS_W-1:0] m);
    return (m == MISS_MAX) ? m : m + MISS_W'(1);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [CTR_W-1:0] c);
    logic [CTR_W+OUT_CNT_W-1:0] w;
    w = (CTR_W + OUT_CNT_W)'(c);
    return (w > (CTR_W + OUT_CNT_W)'(OUT_CNT_MAX)) ? OUT_CNT_W'(OUT_CNT_MAX)
                                                    : w[OUT_CNT_W-1:0];
  endfunction

endpackage

@@ rtl/bpr_ram.sv @@
// generic simple dual-port ram with registered read
module bpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/bpr_useq.sv @@
// microcode sequencer: step counter, control store and jump logic
module bpr_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  bpr_pkg::useq_flags_t flags,
  input  bpr_pkg::kind_t      kind,
  output bpr_pkg::ctl_t       ctl
);

  bpr_pkg::upc_t pc_r;
  bpr_pkg::upc_t pc_nxt;

  assign ctl = bpr_pkg::useq_rom(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    unique case (ctl.cond)
      bpr_pkg::COND_DISPATCH: begin
        if (flags.accept) pc_nxt = bpr_pkg::useq_dispatch(kind);
      end
      bpr_pkg::COND_CTR_END: begin
        if (flags.ctr_end) pc_nxt = ctl.target;
      end
      bpr_pkg::COND_ALWAYS: begin
        pc_nxt = ctl.target;
      end
      bpr_pkg::COND_OUT_FREE: begin
        if (flags.out_free) pc_nxt = ctl.target;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bpr_pkg::UPC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ rtl/bus_presence_roster_unit.sv @@
// top level of the bus presence roster: table datapath, config registers, output register
//
// Keeps a 32-slot table of bus device addresses with saturating miss counts.
// Probe results, end of scan and forget/bump items walk the whole table one
// slot per cycle through the entry ram (registered read): the item is
// accepted, the walk reads every slot, and one apply step makes the change
// and loads the result register. Query items read their one slot before the
// apply step and unknown kinds go straight to it. A result waiting on
// out_tready delays only the apply step of the next item; the next item is
// accepted as soon as the previous one is applied. After reset the table is
// empty and ready at once; the configuration port is always ready.
module bus_presence_roster_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // bus_addr[6:0], present[7], query_slot[12:8], zero above
  input  logic [bpr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [bpr_pkg::KIND_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot_index[4:0], newly_added[5], entry_valid[6], entry_addr[13:7],
  // entry_misses[21:14], entry_stale[22], released_count[28:23],
  // entries_in_use[34:29], zero above
  output logic [bpr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [bpr_pkg::STATUS_W-1:0]    out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = bpr_pkg::SLOT_W;
  localparam int CTR_W  = bpr_pkg::CTR_W;
  localparam int ADDR_W = bpr_pkg::ADDR_W;
  localparam int MISS_W = bpr_pkg::MISS_W;
  localparam int QS_W   = bpr_pkg::QS_W;
  localparam int NTBL   = bpr_pkg::TBL_ENTRIES;

  // sequencer
  bpr_pkg::ctl_t        ctl;
  bpr_pkg::useq_flags_t flags;
  logic                 in_acc;
  logic                 out_free;
  logic                 ctr_end;
  logic                 ap_fire;

  // config
  logic [MISS_W-1:0] stale_r;
  logic [MISS_W-1:0] forget_r;
  logic [ADDR_W-1:0] win_lo_r;
  logic [ADDR_W-1:0] win_hi_r;

  // current item
  bpr_pkg::kind_t    kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic              present_r;
  logic [QS_W-1:0]   qs_r;

  // table walk
  logic [CTR_W-1:0]  ctr_r, ctr_nxt;
  logic              ev_vld_r, ev_vld_nxt;
  logic              ev_age_r, ev_age_nxt;
  logic [SLOT_W-1:0] ev_idx_r;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] fslot_r, fslot_nxt;
  logic [MISS_W-1:0] fmiss_r, fmiss_nxt;
  logic              free_r, free_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;
  logic [CTR_W-1:0]  rel_r, rel_nxt;

  // table state
  logic [NTBL-1:0]   valid_r, valid_nxt;
  logic [NTBL-1:0]   seen_r, seen_nxt;
  logic [CTR_W-1:0]  in_use_r, in_use_nxt;

  // entry ram
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  bpr_pkg::entry_t   ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  bpr_pkg::entry_t   rd_entry;

  // slot evaluation
  logic              ev_hit;
  logic              ev_free;
  logic              age_hit;
  logic              age_rel;
  logic [MISS_W-1:0] age_miss;

  // apply step
  logic              qs_in;
  logic              ap_wr;
  logic [SLOT_W-1:0] ap_slot;
  bpr_pkg::entry_t   ap_wdata;
  logic              ap_set;
  logic              ap_clr;
  logic              ap_inc;
  logic              ap_dec;
  bpr_pkg::status_t  res_status;
  logic [QS_W-1:0]   res_slot;
  logic              res_new;
  logic              rep_en;
  logic [ADDR_W-1:0] rep_addr;
  logic [MISS_W-1:0] rep_miss;
  logic [bpr_pkg::OUT_CNT_W-1:0] res_rel;

  logic [bpr_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [bpr_pkg::STATUS_W-1:0]    out_status_r;
  logic                            out_tvalid_r;

  bpr_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .kind  (bpr_pkg::kind_t'(in_tuser)),
    .ctl   (ctl)
  );

  bpr_ram #(
    .WIDTH (bpr_pkg::ENTRY_W),
    .DEPTH (NTBL)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd_entry)
  );

  assign in_tready      = (ctl.act == bpr_pkg::ACT_LOAD);
  assign in_acc         = in_tvalid && in_tready;
  assign out_free       = !out_tvalid_r || out_tready;
  assign ctr_end        = (ctr_r == CTR_W'(NTBL));
  assign ap_fire        = (ctl.act == bpr_pkg::ACT_APPLY) && out_free;
  assign flags.accept   = in_acc;
  assign flags.ctr_end  = ctr_end;
  assign flags.out_free = out_free;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // query holds its read address until the result is loaded
  assign ram_raddr = ((ctl.act == bpr_pkg::ACT_QREAD) || (ctl.act == bpr_pkg::ACT_APPLY))
                   ? SLOT_W'(qs_r) : ctr_r[SLOT_W-1:0];

  // evaluation of the slot read in the previous cycle
  always_comb begin
    ev_hit   = ev_vld_r && !ev_age_r && !found_r && valid_r[ev_idx_r]
            && (rd_entry.addr == addr_r);
    ev_free  = ev_vld_r && !ev_age_r && !free_r && !valid_r[ev_idx_r];
    age_hit  = ev_vld_r && ev_age_r && valid_r[ev_idx_r] && !seen_r[ev_idx_r];
    age_miss = bpr_pkg::sat_inc(rd_entry.misses);
    age_rel  = age_hit && (age_miss >= forget_r);
  end

  always_comb begin
    qs_in      = (int'(qs_r) < NTBL);
    ap_wr      = 1'b0;
    ap_slot    = fslot_r;
    ap_wdata   = '{misses: '0, addr: addr_r};
    ap_set     = 1'b0;
    ap_clr     = 1'b0;
    ap_inc     = 1'b0;
    ap_dec     = 1'b0;
    res_status = bpr_pkg::ST_OK;
    res_slot   = '0;
    res_new    = 1'b0;
    rep_en     = 1'b0;
    rep_addr   = addr_r;
    rep_miss   = '0;
    res_rel    = '0;
    unique case (kind_r)
      bpr_pkg::KIND_PROBE: begin
        if ((addr_r < win_lo_r) || (addr_r > win_hi_r)) begin
          res_status = bpr_pkg::ST_OUTSIDE;
        end else if (present_r) begin
          if (found_r) begin
            ap_wr  = 1'b1;
            ap_set = 1'b1;
            rep_en = 1'b1;
          end else if (free_r) begin
            ap_slot = free_slot_r;
            ap_wr   = 1'b1;
            ap_set  = 1'b1;
            ap_inc  = 1'b1;
            res_new = 1'b1;
            rep_en  = 1'b1;
          end else begin
            res_status = bpr_pkg::ST_FULL;
          end
        end else if (found_r) begin
          rep_en   = 1'b1;
          rep_miss = fmiss_r;
        end else begin
          res_status = bpr_pkg::ST_NOT_FOUND;
        end
        if (rep_en) res_slot = QS_W'(ap_slot);
      end
      bpr_pkg::KIND_EOS: begin
        res_rel = bpr_pkg::sat_cnt(rel_r);
      end
      bpr_pkg::KIND_FORGET: begin
        if (found_r) begin
          ap_clr   = 1'b1;
          ap_dec   = 1'b1;
          res_slot = QS_W'(fslot_r);
          res_rel  = bpr_pkg::OUT_CNT_W'(1);
        end else begin
          res_status = bpr_pkg::ST_NOT_FOUND;
        end
      end
      bpr_pkg::KIND_BUMP: begin
        if (found_r) begin
          ap_wr    = 1'b1;
          ap_wdata = '{misses: bpr_pkg::sat_inc(fmiss_r), addr: addr_r};
          rep_en   = 1'b1;
          rep_miss = bpr_pkg::sat_inc(fmiss_r);
          res_slot = QS_W'(fslot_r);
        end else begin
          res_status = bpr_pkg::ST_NOT_FOUND;
        end
      end
      bpr_pkg::KIND_QUERY: begin
        res_slot = qs_r;
        if (qs_in && valid_r[SLOT_W'(qs_r)]) begin
          rep_en   = 1'b1;
          rep_addr = rd_entry.addr;
          rep_miss = rd_entry.misses;
        end
      end
      default: begin
      end
    endcase
  end

  // table state and walk registers
  always_comb begin
    valid_nxt     = valid_r;
    seen_nxt      = seen_r;
    in_use_nxt    = in_use_r;
    ctr_nxt       = ctr_r;
    found_nxt     = found_r;
    fslot_nxt     = fslot_r;
    fmiss_nxt     = fmiss_r;
    free_nxt      = free_r;
    free_slot_nxt = free_slot_r;
    rel_nxt       = rel_r;
    ev_vld_nxt    = 1'b0;
    ev_age_nxt    = (ctl.act == bpr_pkg::ACT_AGE);

    if (in_acc) begin
      ctr_nxt   = '0;
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
      rel_nxt   = '0;
    end
    if ((ctl.act == bpr_pkg::ACT_FIND) || (ctl.act == bpr_pkg::ACT_AGE)) begin
      if (!ctr_end) begin
        ctr_nxt    = ctr_r + CTR_W'(1);
        ev_vld_nxt = 1'b1;
      end
    end

    if (ev_hit) begin
      found_nxt = 1'b1;
      fslot_nxt = ev_idx_r;
      fmiss_nxt = rd_entry.misses;
    end
    if (ev_free) begin
      free_nxt      = 1'b1;
      free_slot_nxt = ev_idx_r;
    end
    // end of scan clears every seen mark on its way
    if (ev_vld_r && ev_age_r) seen_nxt[ev_idx_r] = 1'b0;
    if (age_rel) begin
      valid_nxt[ev_idx_r] = 1'b0;
      rel_nxt             = rel_r + CTR_W'(1);
      in_use_nxt          = in_use_r - CTR_W'(1);
    end

    if (ap_fire) begin
      if (ap_set) begin
        valid_nxt[ap_slot] = 1'b1;
        seen_nxt[ap_slot]  = 1'b1;
      end
      if (ap_clr) begin
        valid_nxt[ap_slot] = 1'b0;
        seen_nxt[ap_slot]  = 1'b0;
      end
      if (ap_inc) in_use_nxt = in_use_r + CTR_W'(1);
      if (ap_dec) in_use_nxt = in_use_r - CTR_W'(1);
    end

    ram_we    = age_hit || (ap_fire && ap_wr);
    ram_waddr = age_hit ? ev_idx_r : ap_slot;
    ram_wdata = age_hit ? '{misses: age_miss, addr: rd_entry.addr} : ap_wdata;

    out_data_nxt = bpr_pkg::OUT_TDATA_W'({bpr_pkg::sat_cnt(in_use_nxt), res_rel,
                                          rep_en && (rep_miss >= stale_r),
                                          rep_en ? rep_miss : MISS_W'(0),
                                          rep_en ? rep_addr : ADDR_W'(0),
                                          rep_en, res_new, res_slot});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r      <= bpr_pkg::RST_STALE;
      forget_r     <= bpr_pkg::RST_FORGET;
      win_lo_r     <= bpr_pkg::RST_WIN_LO;
      win_hi_r     <= bpr_pkg::RST_WIN_HI;
      ctr_r        <= '0;
      ev_vld_r     <= 1'b0;
      ev_age_r     <= 1'b0;
      found_r      <= 1'b0;
      free_r       <= 1'b0;
      rel_r        <= '0;
      valid_r      <= '0;
      seen_r       <= '0;
      in_use_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (bpr_pkg::cfg_idx_t'(cfg_index))
          bpr_pkg::CFG_STALE:  stale_r  <= cfg_data;
          bpr_pkg::CFG_FORGET: forget_r <= cfg_data;
          bpr_pkg::CFG_WIN_LO: win_lo_r <= cfg_data[ADDR_W-1:0];
          bpr_pkg::CFG_WIN_HI: win_hi_r <= cfg_data[ADDR_W-1:0];
        endcase
      end
      ctr_r    <= ctr_nxt;
      ev_vld_r <= ev_vld_nxt;
      ev_age_r <= ev_age_nxt;
      found_r  <= found_nxt;
      free_r   <= free_nxt;
      rel_r    <= rel_nxt;
      valid_r  <= valid_nxt;
      seen_r   <= seen_nxt;
      in_use_r <= in_use_nxt;
      if (ap_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r    <= bpr_pkg::kind_t'(in_tuser);
      addr_r    <= in_tdata[ADDR_W-1:0];
      present_r <= in_tdata[ADDR_W];
      qs_r      <= in_tdata[ADDR_W+1 +: QS_W];
    end
    ev_idx_r    <= ctr_r[SLOT_W-1:0];
    fslot_r     <= fslot_nxt;
    fmiss_r     <= fmiss_nxt;
    free_slot_r <= free_slot_nxt;
    if (ap_fire) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= res_status;
    end
  end

  // occupancy counter tracks the valid bits
  a_in_use_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r == CTR_W'($countones(valid_r)))
    else $error("occupancy count differs from valid bits");

  // a seen mark only sits on a valid slot
  a_seen_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r & ~valid_r) == '0)
    else $error("seen mark on a free slot");

  // applying an item returns the sequencer to accepting
  a_apply_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ap_fire |=> in_tready)
    else $error("sequencer not idle after apply");

  // the slot walk only runs while the counter is inside the table
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> (ctr_r != '0) && (ctr_r <= CTR_W'(NTBL)))
    else $error("slot walk outside the table");

endmodule

@@ test/bus_presence_roster_unit_tb.sv @@
// self-checking testbench for the bus presence roster: directed and scan-shaped random traffic
module bus_presence_roster_unit_tb;

  localparam int KIND_W      = bpr_pkg::KIND_W;
  localparam int ADDR_W      = bpr_pkg::ADDR_W;
  localparam int QS_W        = bpr_pkg::QS_W;
  localparam int SLOT_W      = bpr_pkg::SLOT_W;
  localparam int MISS_W      = bpr_pkg::MISS_W;
  localparam int OUT_CNT_W   = bpr_pkg::OUT_CNT_W;
  localparam int OUT_CNT_MAX = bpr_pkg::OUT_CNT_MAX;
  localparam int TBL_ENTRIES = bpr_pkg::TBL_ENTRIES;
  localparam int IN_TDATA_W  = bpr_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = bpr_pkg::OUT_TDATA_W;
  localparam int STATUS_W    = bpr_pkg::STATUS_W;
  localparam int CFG_IDX_W   = bpr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = bpr_pkg::CFG_DATA_W;
  localparam logic [MISS_W-1:0] MISS_MAX = bpr_pkg::MISS_MAX;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [KIND_W-1:0] KIND_TOP = '1;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;
  localparam logic [QS_W-1:0]   SLOT_TOP = QS_W'(TBL_ENTRIES - 1);
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic              present;
    logic [QS_W-1:0]   qs;
  } roster_item_t;

  typedef struct packed {
    bpr_pkg::status_t     status;
    logic [SLOT_W-1:0]    slot;
    logic                 newly;
    logic                 evalid;
    logic [ADDR_W-1:0]    eaddr;
    logic [MISS_W-1:0]    emiss;
    logic                 estale;
    logic [OUT_CNT_W-1:0] released;
    logic [OUT_CNT_W-1:0] in_use;
    logic [4:0]           pad;
  } roster_report_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bus_presence_roster_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow of the roster and its registers
  logic [MISS_W-1:0] thr_stale  = bpr_pkg::RST_STALE;
  logic [MISS_W-1:0] thr_forget = bpr_pkg::RST_FORGET;
  logic [ADDR_W-1:0] win_lo     = bpr_pkg::RST_WIN_LO;
  logic [ADDR_W-1:0] win_hi     = bpr_pkg::RST_WIN_HI;
  logic              tbl_valid [TBL_ENTRIES] = '{default: 1'b0};
  logic [ADDR_W-1:0] tbl_addr  [TBL_ENTRIES] = '{default: '0};
  logic [MISS_W-1:0] tbl_miss  [TBL_ENTRIES] = '{default: '0};
  logic              tbl_seen  [TBL_ENTRIES] = '{default: 1'b0};

  roster_item_t   item_backlog [$];
  roster_report_t pending_reports [$];

  roster_item_t   cur_item;
  roster_report_t got, want;
  int             items_offered = 0;
  int             items_accepted = 0;
  logic           steady = 1'b0;
  logic           long_hold_done = 1'b0;
  int             send_gap = 0;
  int             hold_left = 0;
  int             cfg_writes = 0;
  int             settings_applied = 0;
  int             reports_seen = 0;
  int             fail_count = 0;
  int             max_miss_seen = 0;
  int             kind_count [KIND_TOP+1] = '{default: 0};
  int             status_count [4] = '{default: 0};
  int             cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int find_slot(input logic [ADDR_W-1:0] a);
    for (int i = 0; i < TBL_ENTRIES; i++)
      if (tbl_valid[i] && tbl_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic void show_slot(inout roster_report_t r, input int s);
    r.slot = s[SLOT_W-1:0];
    if (tbl_valid[s]) begin
      r.evalid = 1'b1;
      r.eaddr  = tbl_addr[s];
      r.emiss  = tbl_miss[s];
      r.estale = (tbl_miss[s] >= thr_stale);
    end
  endfunction

  function automatic roster_report_t step_roster(input roster_item_t it);
    roster_report_t r;
    int s, f, rel, n;
    r = '0;
    s = find_slot(it.addr);
    case (it.kind)
      bpr_pkg::KIND_PROBE: begin
        if (it.addr < win_lo || it.addr > win_hi) begin
          r.status = bpr_pkg::ST_OUTSIDE;
        end else if (s >= 0) begin
          if (it.present) begin
            tbl_miss[s] = '0;
            tbl_seen[s] = 1'b1;
          end
          show_slot(r, s);
        end else if (!it.present) begin
          r.status = bpr_pkg::ST_NOT_FOUND;
        end else begin
          f = -1;
          for (int i = TBL_ENTRIES - 1; i >= 0; i--)
            if (!tbl_valid[i]) f = i;
          if (f < 0) begin
            r.status = bpr_pkg::ST_FULL;
          end else begin
            tbl_valid[f] = 1'b1;
            tbl_addr[f]  = it.addr;
            tbl_miss[f]  = '0;
            tbl_seen[f]  = 1'b1;
            r.newly      = 1'b1;
            show_slot(r, f);
          end
        end
      end
      bpr_pkg::KIND_EOS: begin
        rel = 0;
        for (int i = 0; i < TBL_ENTRIES; i++) begin
          if (tbl_valid[i] && !tbl_seen[i]) begin
            if (tbl_miss[i] != MISS_MAX) tbl_miss[i] = tbl_miss[i] + 1'b1;
            if (tbl_miss[i] >= thr_forget) begin
              tbl_valid[i] = 1'b0;
              rel++;
            end
          end
          tbl_seen[i] = 1'b0;
        end
        r.released = OUT_CNT_W'((rel > OUT_CNT_MAX) ? OUT_CNT_MAX : rel);
      end
      bpr_pkg::KIND_FORGET: begin
        if (s >= 0) begin
          tbl_valid[s] = 1'b0;
          tbl_seen[s]  = 1'b0;
          r.slot       = s[SLOT_W-1:0];
          r.released   = OUT_CNT_W'(1);
        end else begin
          r.status = bpr_pkg::ST_NOT_FOUND;
        end
      end
      bpr_pkg::KIND_BUMP: begin
        if (s >= 0) begin
          if (tbl_miss[s] != MISS_MAX) tbl_miss[s] = tbl_miss[s] + 1'b1;
          show_slot(r, s);
        end else begin
          r.status = bpr_pkg::ST_NOT_FOUND;
        end
      end
      bpr_pkg::KIND_QUERY: begin
        r.slot = it.qs;
        if (it.qs < TBL_ENTRIES) show_slot(r, it.qs);
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < TBL_ENTRIES; i++)
      if (tbl_valid[i]) n++;
    r.in_use = OUT_CNT_W'((n > OUT_CNT_MAX) ? OUT_CNT_MAX : n);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned seen_val,
                               input longint unsigned want_val);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch at result %0d: %s is %0d, expected %0d", reports_seen, what,
               seen_val, want_val);
  endtask

  // accept items, apply register writes and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (bpr_pkg::cfg_idx_t'(cfg_index))
        bpr_pkg::CFG_STALE:  thr_stale  = cfg_data;
        bpr_pkg::CFG_FORGET: thr_forget = cfg_data;
        bpr_pkg::CFG_WIN_LO: win_lo     = cfg_data[ADDR_W-1:0];
        bpr_pkg::CFG_WIN_HI: win_hi     = cfg_data[ADDR_W-1:0];
      endcase
      cfg_writes++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = bpr_pkg::status_t'(out_tuser);
      got.slot     = out_tdata[4:0];
      got.newly    = out_tdata[5];
      got.evalid   = out_tdata[6];
      got.eaddr    = out_tdata[13:7];
      got.emiss    = out_tdata[21:14];
      got.estale   = out_tdata[22];
      got.released = out_tdata[28:23];
      got.in_use   = out_tdata[34:29];
      got.pad      = out_tdata[39:35];
      reports_seen++;
      if (pending_reports.size() == 0) begin
        note_mismatch("result with nothing outstanding, tdata", out_tdata, 0);
      end else begin
        want = pending_reports.pop_front();
        status_count[want.status]++;
        if (want.emiss > max_miss_seen) max_miss_seen = want.emiss;
        if (got.status != want.status) note_mismatch("status", got.status, want.status);
        if (got.slot != want.slot) note_mismatch("slot_index", got.slot, want.slot);
        if (got.newly != want.newly) note_mismatch("newly_added", got.newly, want.newly);
        if (got.evalid != want.evalid) note_mismatch("entry_valid", got.evalid, want.evalid);
        if (got.eaddr != want.eaddr) note_mismatch("entry_addr", got.eaddr, want.eaddr);
        if (got.emiss != want.emiss) note_mismatch("entry_misses", got.emiss, want.emiss);
        if (got.estale != want.estale) note_mismatch("entry_stale", got.estale, want.estale);
        if (got.released != want.released)
          note_mismatch("released_count", got.released, want.released);
        if (got.in_use != want.in_use)
          note_mismatch("entries_in_use", got.in_use, want.in_use);
        if (got.pad != want.pad) note_mismatch("tdata padding", got.pad, want.pad);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      cur_item.kind    = in_tuser;
      cur_item.addr    = in_tdata[6:0];
      cur_item.present = in_tdata[7];
      cur_item.qs      = in_tdata[12:8];
      kind_count[cur_item.kind]++;
      pending_reports.push_back(step_roster(cur_item));
      items_accepted++;
    end
  end

  // ------------------------------------------------------------------ driving

  always @(negedge clk) begin
    roster_item_t it;
    if (rst_n && (!in_tvalid || items_accepted == items_offered)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (item_backlog.size() != 0 && !steady && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 10) - 1;
        in_tvalid <= 1'b0;
      end else if (item_backlog.size() != 0) begin
        it = item_backlog.pop_front();
        items_offered++;
        in_tvalid <= 1'b1;
        in_tuser  <= it.kind;
        in_tdata  <= {3'b000, it.qs, it.present, it.addr};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls, with one long hold-off early on so the block backs up
  always @(negedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && reports_seen >= 60) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 10) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [ADDR_W-1:0] rnd_addr();
    return ADDR_W'($urandom_range(0, ADDR_TOP));
  endfunction

  function automatic logic [QS_W-1:0] rnd_slot();
    return QS_W'($urandom_range(0, SLOT_TOP));
  endfunction

  function automatic void queue_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                                     input logic p, input logic [QS_W-1:0] q);
    roster_item_t it;
    it.kind    = k;
    it.addr    = a;
    it.present = p;
    it.qs      = q;
    item_backlog.push_back(it);
  endfunction

  function automatic void queue_noise(input logic [ADDR_W-1:0] near);
    logic [ADDR_W-1:0] a;
    a = rnd_bit() ? rnd_addr() : near;
    case ($urandom_range(0, 5))
      0: queue_item(bpr_pkg::KIND_FORGET, a, rnd_bit(), rnd_slot());
      1: queue_item(bpr_pkg::KIND_BUMP, a, rnd_bit(), rnd_slot());
      2: queue_item(bpr_pkg::KIND_QUERY, rnd_addr(), rnd_bit(), rnd_slot());
      3: queue_item(KIND_W'($urandom_range(int'(bpr_pkg::KIND_QUERY) + 1, KIND_TOP)),
                    rnd_addr(), rnd_bit(), rnd_slot());
      4: queue_item(bpr_pkg::KIND_PROBE, rnd_addr(), rnd_bit(), rnd_slot());
      default: queue_item(bpr_pkg::KIND_EOS, a, rnd_bit(), rnd_slot());
    endcase
  endfunction

  // scan passes over a device population, each closed by an end of scan
  task automatic queue_scan_traffic(input int n_items, input int pop_size);
    logic [ADDR_W-1:0] pop [$];
    int n, r;
    for (int i = 0; i < pop_size; i++) begin
      if (win_lo <= win_hi && $urandom_range(0, 9) < 8)
        pop.push_back(ADDR_W'($urandom_range(win_lo, win_hi)));
      else
        pop.push_back(rnd_addr());
    end
    n = 0;
    while (n < n_items) begin
      foreach (pop[j]) begin
        if (n >= n_items) break;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          queue_item(bpr_pkg::KIND_PROBE, pop[j], 1'b1, rnd_slot());
          n++;
        end else if (r < 82) begin
          queue_item(bpr_pkg::KIND_PROBE, pop[j], 1'b0, rnd_slot());
          n++;
        end
        if ($urandom_range(0, 99) < 12) begin
          queue_noise(pop[j]);
          n++;
        end
      end
      queue_item(bpr_pkg::KIND_EOS, rnd_addr(), rnd_bit(), rnd_slot());
      n++;
    end
  endtask

  task automatic write_reg(input bpr_pkg::cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    int before_count;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    before_count = cfg_writes;
    do @(negedge clk); while (cfg_writes == before_count);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_roster_cfg(input logic [7:0] stale, input logic [7:0] forget,
                                input logic [7:0] lo, input logic [7:0] hi);
    write_reg(bpr_pkg::CFG_STALE, stale);
    write_reg(bpr_pkg::CFG_FORGET, forget);
    write_reg(bpr_pkg::CFG_WIN_LO, lo);
    write_reg(bpr_pkg::CFG_WIN_HI, hi);
    settings_applied++;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (item_backlog.size() != 0 || in_tvalid || pending_reports.size() != 0);
  endtask

  initial begin
    logic [7:0] lo;
    while (!rst_n) @(posedge clk);

    // directed part under the reset register values (window 8..39)
    queue_item(bpr_pkg::KIND_PROBE, 7, 1'b1, 0);             // just below the window
    queue_item(bpr_pkg::KIND_PROBE, 40, 1'b1, 0);            // just above
    queue_item(bpr_pkg::KIND_PROBE, ADDR_TOP, 1'b1, SLOT_TOP);
    queue_item(bpr_pkg::KIND_PROBE, 0, 1'b0, 0);
    queue_item(bpr_pkg::KIND_PROBE, 8, 1'b0, 0);             // absent, not held
    queue_item(bpr_pkg::KIND_PROBE, 8, 1'b1, 0);             // claims slot 0
    queue_item(bpr_pkg::KIND_PROBE, 39, 1'b1, 0);            // claims slot 1
    queue_item(bpr_pkg::KIND_PROBE, 8, 1'b1, 0);             // found again
    queue_item(bpr_pkg::KIND_PROBE, 39, 1'b0, 0);            // absent but held
    queue_item(bpr_pkg::KIND_BUMP, 39, 1'b0, 0);
    queue_item(bpr_pkg::KIND_BUMP, 100, 1'b0, 0);
    queue_item(bpr_pkg::KIND_FORGET, 90, 1'b1, 0);
    queue_item(bpr_pkg::KIND_QUERY, 0, 1'b0, 1);
    queue_item(bpr_pkg::KIND_QUERY, 0, 1'b0, SLOT_TOP);      // never held an entry
    queue_item(bpr_pkg::KIND_EOS, 0, 1'b0, 0);               // both seen, nothing ages
    queue_item(bpr_pkg::KIND_EOS, 0, 1'b0, 0);
    queue_item(bpr_pkg::KIND_BUMP, 39, 1'b0, 0);
    queue_item(bpr_pkg::KIND_BUMP, 39, 1'b1, 0);             // stays past the stale mark
    queue_item(bpr_pkg::KIND_FORGET, 8, 1'b0, 0);
    queue_item(bpr_pkg::KIND_QUERY, ADDR_TOP, 1'b1, 0);      // slot released
    queue_item(KIND_W'(bpr_pkg::KIND_QUERY + 1), ADDR_TOP, 1'b1, SLOT_TOP);
    queue_item(KIND_W'(bpr_pkg::KIND_QUERY + 2), 39, 1'b0, 1);
    queue_item(KIND_TOP, 8, 1'b1, 0);
    queue_item(bpr_pkg::KIND_EOS, 0, 1'b0, 0);
    queue_item(bpr_pkg::KIND_EOS, 0, 1'b0, 0);               // reaches forget threshold
    queue_item(bpr_pkg::KIND_QUERY, 0, 1'b0, 1);
    drain();

    set_roster_cfg(bpr_pkg::RST_STALE, bpr_pkg::RST_FORGET,
                   8'(bpr_pkg::RST_WIN_LO), 8'(bpr_pkg::RST_WIN_HI));
    queue_scan_traffic(120, 20);
    drain();

    // widest window and lowest thresholds: the roster fills up
    set_roster_cfg(8'd1, 8'd1, 8'd0, 8'd127);
    queue_scan_traffic(148, 45);
    queue_item(bpr_pkg::KIND_EOS, 0, 1'b0, 0);
    queue_item(bpr_pkg::KIND_EOS, 0, 1'b0, 0);               // empties the roster
    drain();

    // single-address window, miss count driven to saturation
    set_roster_cfg(8'd255, 8'd255, 8'd127, 8'd127);
    queue_item(bpr_pkg::KIND_PROBE, ADDR_TOP, 1'b1, 0);
    for (int i = 0; i < 280; i++) begin
      if (i % 16 == 7) queue_item(bpr_pkg::KIND_QUERY, ADDR_TOP, 1'b0, 0);
      else queue_item(bpr_pkg::KIND_BUMP, ADDR_TOP, rnd_bit(), rnd_slot());
    end
    queue_item(bpr_pkg::KIND_PROBE, ADDR_W'(ADDR_TOP - 1), 1'b1, 0);
    queue_item(bpr_pkg::KIND_EOS, 0, 1'b0, 0);
    queue_item(bpr_pkg::KIND_QUERY, ADDR_TOP, 1'b1, 0);
    drain();

    // empty window, top data bit set on the address registers
    set_roster_cfg(8'($urandom_range(1, 255)), 8'($urandom_range(1, 4)), 8'hE4, 8'h94);
    queue_scan_traffic(50, 10);
    drain();

    lo = 8'($urandom_range(0, 30));
    set_roster_cfg(8'($urandom_range(1, 6)), 8'($urandom_range(2, 8)), lo,
                   8'(lo + $urandom_range(20, 60)));
    queue_scan_traffic(130, 30);
    drain();

    steady = 1'b1;
    set_roster_cfg(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
                   8'($urandom_range(0, 20)), 8'($urandom_range(60, 127)));
    queue_scan_traffic(120, 24);
    drain();

    repeat (40) @(posedge clk);
    if (pending_reports.size() != 0)
      note_mismatch("results never delivered", pending_reports.size(), 0);
    $display("covered %0d results: probe %0d, end of scan %0d, forget %0d, bump %0d, query %0d",
             reports_seen, kind_count[bpr_pkg::KIND_PROBE], kind_count[bpr_pkg::KIND_EOS],
             kind_count[bpr_pkg::KIND_FORGET], kind_count[bpr_pkg::KIND_BUMP],
             kind_count[bpr_pkg::KIND_QUERY]);
    $display("statuses ok %0d, full %0d, not held %0d, outside %0d; peak misses %0d; %0d settings",
             status_count[bpr_pkg::ST_OK], status_count[bpr_pkg::ST_FULL],
             status_count[bpr_pkg::ST_NOT_FOUND], status_count[bpr_pkg::ST_OUTSIDE],
             max_miss_seen, settings_applied);
    if (fail_count == 0) begin
      $display("bus_presence_roster_unit regression: pass");
    end else begin
      $display("bus_presence_roster_unit regression: fail");
    end
    $finish;
  end

  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_reports.size());
    $display("bus_presence_roster_unit regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bpr_pkg.sv
rtl/bpr_ram.sv
rtl/bpr_useq.sv
rtl/bus_presence_roster_unit.sv
test/bus_presence_roster_unit_tb.sv
